@@ rtl/pxe_pkg.sv @@
// Shared types and codes for the prefix expression evaluator.
package pxe_pkg;

    localparam int unsigned WordW = 32;

    typedef logic signed [WordW-1:0] t_word;

    // Token operation codes
    localparam logic [2:0] OP_PUSH = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;

    // Result status codes
    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_UNDERFLOW = 2'd1,
        STS_DIVZERO   = 2'd2,
        STS_OVERFLOW  = 2'd3
    } t_status;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_OPER,
        ST_DIV,
        ST_FIN
    } t_state;

endpackage

@@ rtl/prefix_expression_evaluator.sv @@
// Prefix expression evaluator top level: stack sequencer around the stack memory.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------------
//  token   | in        | i_valid / o_stall  | i_operation, i_operand_value, i_last_token
//  result  | out       | o_valid / i_stall  | o_expression_value, o_status
//
// Each token passes ST_EXEC; an operator with two entries stacked goes on to ST_OPER, a
// divide by a nonzero divisor then waits in ST_DIV, and the last token ends in ST_FIN.
// The divide wait comes from the one-bit-per-cycle divider; ST_OPER from the registered
// read of the stack memory (top of stack is held in a register).
// Reset (synchronous, active low) empties the stack and clears the error status.
// A result waiting under i_stall does not hold off the next request; only a second
// result behind it does.
module prefix_expression_evaluator #(
    parameter int unsigned STACK_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [2:0]        i_operation,
    input  pxe_pkg::t_word    i_operand_value,
    input  logic              i_last_token,
    output logic              o_valid,
    input  logic              i_stall,
    output pxe_pkg::t_word    o_expression_value,
    output pxe_pkg::t_status  o_status
);
    import pxe_pkg::*;

    localparam int unsigned AW = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

    t_state     r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    t_status    r_err, n_err;
    t_word      r_tos, n_tos;
    logic [2:0] r_op;
    t_word      r_val;
    logic       r_last;
    logic       r_out_valid, n_out_valid;
    t_word      r_out_value, n_out_value;
    t_status    r_out_status, n_out_status;

    logic          w_accept;
    logic          w_is_oper;
    logic          w_full;
    logic          w_two;
    logic          w_emit;
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;
    t_word         w_rd_data;
    logic          w_div_start;
    logic          w_div_done;
    t_word         w_quot;
    t_word         w_sum;
    t_word         w_dif;
    t_word         w_prod;

    assign w_accept  = i_valid && !o_stall;
    assign w_is_oper = (r_op == OP_ADD) || (r_op == OP_SUB) || (r_op == OP_MUL)
                       || (r_op == OP_DIV);
    assign w_full    = (r_count == CW'(STACK_DEPTH));
    assign w_two     = (r_count >= CW'(2));
    assign w_emit    = (r_state == ST_FIN) && (!r_out_valid || !i_stall);

    // memory holds every entry below the top of stack
    assign w_wr_addr = AW'(r_count - CW'(1));
    assign w_rd_addr = AW'(r_count - CW'(2));

    // left operand is the top of stack, right operand the entry below
    assign w_sum  = r_tos + w_rd_data;
    assign w_dif  = r_tos - w_rd_data;
    assign w_prod = r_tos * w_rd_data;

    pxe_stack_mem #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (r_tos),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    pxe_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_tos),
        .i_divisor  (w_rd_data),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (w_is_oper && w_two) n_state = ST_OPER;
                else if (r_last)        n_state = ST_FIN;
                else                    n_state = ST_IDLE;
            end
            ST_OPER: begin
                if (r_op == OP_DIV && w_rd_data != '0) n_state = ST_DIV;
                else if (r_last)                       n_state = ST_FIN;
                else                                   n_state = ST_IDLE;
            end
            ST_DIV: begin
                if (w_div_done) n_state = r_last ? ST_FIN : ST_IDLE;
            end
            ST_FIN: begin
                if (w_emit) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        w_wr_en     = 1'b0;
        w_rd_en     = 1'b0;
        w_div_start = 1'b0;
        unique case (r_state)
            ST_EXEC: begin
                w_wr_en = (r_op == OP_PUSH) && !w_full && (r_count != '0);
                w_rd_en = w_is_oper && w_two;
            end
            ST_OPER: begin
                w_div_start = (r_op == OP_DIV) && (w_rd_data != '0);
            end
            default: ;
        endcase
    end

    assign o_stall = (r_state != ST_IDLE);

    // stack, error and result updates
    always_comb begin
        n_count      = r_count;
        n_err        = r_err;
        n_tos        = r_tos;
        n_out_valid  = r_out_valid && i_stall;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        case (r_state)
            ST_EXEC: begin
                if (r_op == OP_PUSH) begin
                    if (w_full) begin
                        if (r_err == STS_OK) n_err = STS_OVERFLOW;
                    end else begin
                        n_tos   = r_val;
                        n_count = r_count + CW'(1);
                    end
                end else if (w_is_oper && !w_two) begin
                    if (r_err == STS_OK) n_err = STS_UNDERFLOW;
                end
            end
            ST_OPER: begin
                n_count = r_count - CW'(1);
                case (r_op)
                    OP_ADD: n_tos = w_sum;
                    OP_SUB: n_tos = w_dif;
                    OP_MUL: n_tos = w_prod;
                    default: begin
                        // divide by zero pushes zero; nonzero waits for the divider
                        if (w_rd_data == '0) begin
                            n_tos = '0;
                            if (r_err == STS_OK) n_err = STS_DIVZERO;
                        end
                    end
                endcase
            end
            ST_DIV: begin
                if (w_div_done) n_tos = w_quot;
            end
            ST_FIN: begin
                if (w_emit) begin
                    n_out_valid = 1'b1;
                    if (r_count == '0) begin
                        n_out_value  = '0;
                        n_out_status = (r_err == STS_OK) ? STS_UNDERFLOW : r_err;
                    end else begin
                        n_out_value  = r_tos;
                        n_out_status = r_err;
                    end
                    n_count = '0;
                    n_err   = STS_OK;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_err       <= STS_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= i_operation;
            r_val  <= i_operand_value;
            r_last <= i_last_token;
        end
        r_tos        <= n_tos;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    assign o_valid            = r_out_valid;
    assign o_expression_value = r_out_value;
    assign o_status           = r_out_status;

    // stack never holds more than its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // divider finishes only while the sequencer waits on it
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DIV))
        else $error("divider done outside divide wait");

    // a result leaves the stack and status cleared
    a_clear_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (r_count == '0) && (r_err == STS_OK) && o_valid)
        else $error("stack not cleared after result");

    // an empty stack at the end never reports ok
    a_empty_not_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && (r_count == '0)) |=> (o_status != STS_OK) && (o_expression_value == '0))
        else $error("empty stack reported as ok");

endmodule

@@ rtl/pxe_stack_mem.sv @@
// Value stack storage: one write port, one read port, registered read data.
module pxe_stack_mem #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  pxe_pkg::t_word    i_wr_data,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output pxe_pkg::t_word    o_rd_data
);
    import pxe_pkg::*;

    t_word r_mem [DEPTH];
    t_word r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/pxe_div.sv @@
// Signed 32-bit divider, restoring, one quotient bit per cycle, truncates toward zero.
module pxe_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  pxe_pkg::t_word    i_dividend,
    input  pxe_pkg::t_word    i_divisor,
    output logic              o_done,
    output pxe_pkg::t_word    o_quotient
);
    import pxe_pkg::*;

    logic               r_busy;
    logic               r_done;
    logic [4:0]         r_cnt;
    logic [WordW-1:0]   r_rem;
    logic [WordW-1:0]   r_quo;
    logic [WordW-1:0]   r_dvs;
    logic               r_neg;

    logic [WordW:0]     w_shift;
    logic [WordW:0]     w_diff;
    logic [WordW-1:0]   w_mag_a;
    logic [WordW-1:0]   w_mag_b;

    // magnitudes; the most negative value maps to 2^31 unsigned
    assign w_mag_a = i_dividend[WordW-1] ? (WordW)'(-i_dividend) : i_dividend;
    assign w_mag_b = i_divisor[WordW-1]  ? (WordW)'(-i_divisor)  : i_divisor;

    // trial subtract of one step
    assign w_shift = {r_rem, r_quo[WordW-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd31;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= w_mag_a;
            r_dvs <= w_mag_b;
            r_neg <= i_dividend[WordW-1] ^ i_divisor[WordW-1];
        end else if (r_busy) begin
            if (!w_diff[WordW]) begin
                r_rem <= w_diff[WordW-1:0];
                r_quo <= {r_quo[WordW-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[WordW-1:0];
                r_quo <= {r_quo[WordW-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? t_word'(-r_quo) : t_word'(r_quo);

endmodule

@@ tb/prefix_expression_evaluator_checker.sv @@
// Checker for the prefix expression evaluator: stack predictor and result comparison.
`timescale 1ns / 1ps

module prefix_expression_evaluator_checker #(
    parameter int unsigned STACK_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // token channel
    input  logic              i_token_valid,
    input  logic              i_token_stall,
    input  logic [2:0]        i_operation,
    input  pxe_pkg::t_word    i_operand_value,
    input  logic              i_last_token,
    // result channel
    input  logic              i_result_valid,
    input  logic              i_result_stall,
    input  pxe_pkg::t_word    i_expression_value,
    input  pxe_pkg::t_status  i_status,
    // end of run: anything still expected is a failure
    input  logic              i_end_check,
    output int                o_error_count,
    output int                o_pending,
    output int                o_token_count,
    output int                o_result_count,
    output int                o_flagged_count
);
    import pxe_pkg::*;

    typedef struct packed {
        t_word   value;
        t_status status;
    } t_expr_result;

    // Predicted evaluator state
    t_word        operand_stack [STACK_DEPTH];
    int           stack_depth;
    t_status      held_status;
    t_expr_result expected_results [$];
    logic         end_checked;

    initial begin
        o_error_count   = 0;
        o_pending       = 0;
        o_token_count   = 0;
        o_result_count  = 0;
        o_flagged_count = 0;
        stack_depth     = 0;
        held_status     = STS_OK;
        end_checked     = 1'b0;
    end

    task automatic report_mismatch(input string what);
        if (o_error_count < 40) begin
            $display("[%0t] MISMATCH: %s", $time, what);
        end
        o_error_count++;
    endtask

    // First error of an expression is the one reported
    task automatic flag_error(input t_status code);
        if (held_status == STS_OK) begin
            held_status = code;
        end
    endtask

    // lhs is the value popped first; divide by zero is handled by the caller
    function automatic t_word combine_operands(logic [2:0] op, t_word lhs, t_word rhs);
        longint quotient;
        case (op)
            OP_ADD: begin
                return lhs + rhs;
            end
            OP_SUB: begin
                return lhs - rhs;
            end
            OP_MUL: begin
                return lhs * rhs;
            end
            default: begin
                // 64-bit divide so that the most negative value over -1 wraps back
                quotient = longint'(lhs) / longint'(rhs);
                return t_word'(quotient[31:0]);
            end
        endcase
    endfunction

    // Apply one accepted token; the last token queues the expected result
    task automatic evaluate_token(input logic [2:0] op, input t_word operand, input logic last);
        t_word        lhs;
        t_word        rhs;
        t_expr_result outcome;
        if (op == OP_PUSH) begin
            if (stack_depth >= STACK_DEPTH) begin
                flag_error(STS_OVERFLOW);
            end else begin
                operand_stack[stack_depth] = operand;
                stack_depth++;
            end
        end else if (op <= OP_DIV) begin
            if (stack_depth < 2) begin
                flag_error(STS_UNDERFLOW);
            end else begin
                lhs = operand_stack[stack_depth-1];
                rhs = operand_stack[stack_depth-2];
                if (op == OP_DIV && rhs == '0) begin
                    flag_error(STS_DIVZERO);
                    operand_stack[stack_depth-2] = '0;
                end else begin
                    operand_stack[stack_depth-2] = combine_operands(op, lhs, rhs);
                end
                stack_depth--;
            end
        end
        // codes above divide leave the stack alone

        if (last) begin
            if (stack_depth == 0) begin
                flag_error(STS_UNDERFLOW);
                outcome.value = '0;
            end else begin
                outcome.value = operand_stack[stack_depth-1];
            end
            outcome.status = held_status;
            expected_results.push_back(outcome);
            stack_depth = 0;
            held_status = STS_OK;
        end
    endtask

    // Watch both channels at each edge
    always @(posedge i_clk) begin
        t_expr_result want;
        if (!i_rst_n) begin
            stack_depth = 0;
            held_status = STS_OK;
            expected_results.delete();
        end else begin
            if (i_token_valid && !i_token_stall) begin
                evaluate_token(i_operation, i_operand_value, i_last_token);
                o_token_count++;
            end
            if (i_result_valid && !i_result_stall) begin
                o_result_count++;
                if (i_status != STS_OK) begin
                    o_flagged_count++;
                end
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result value %0d status %0d",
                                              i_expression_value, i_status));
                end else begin
                    want = expected_results.pop_front();
                    if (i_expression_value !== want.value) begin
                        report_mismatch($sformatf("result %0d: value %0d, expected %0d",
                                                  o_result_count, i_expression_value,
                                                  want.value));
                    end
                    if (i_status !== want.status) begin
                        report_mismatch($sformatf("result %0d: status %0d, expected %s",
                                                  o_result_count, i_status,
                                                  want.status.name()));
                    end
                end
            end
            if (i_end_check && !end_checked) begin
                end_checked = 1'b1;
                if (expected_results.size() != 0) begin
                    report_mismatch($sformatf("%0d expected results never arrived",
                                              expected_results.size()));
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

@@ tb/tb_prefix_expression_evaluator.sv @@
// Testbench top for the prefix expression evaluator: clock, reset, token stimulus, verdict.
`timescale 1ns / 1ps

module tb_prefix_expression_evaluator;
    import pxe_pkg::*;

    localparam int unsigned STACK_DEPTH = 16;
    localparam int          PHASE_ITEMS = 258;
    localparam t_word       WORD_MIN    = 32'sh8000_0000;
    localparam t_word       WORD_MAX    = 32'sh7fff_ffff;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_valid         = 1'b0;
    logic [2:0]  i_operation     = OP_PUSH;
    t_word       i_operand_value = '0;
    logic        i_last_token    = 1'b0;
    logic        i_stall         = 1'b0;
    logic        o_stall;
    logic        o_valid;
    t_word       o_expression_value;
    t_status     o_status;

    logic        end_check = 1'b0;
    int          error_count;
    int          pending_results;
    int          token_count;
    int          result_count;
    int          flagged_count;

    int          items_sent     = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;

    prefix_expression_evaluator #(
        .STACK_DEPTH (STACK_DEPTH)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_operation        (i_operation),
        .i_operand_value    (i_operand_value),
        .i_last_token       (i_last_token),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_expression_value (o_expression_value),
        .o_status           (o_status)
    );

    prefix_expression_evaluator_checker #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_token_valid      (i_valid),
        .i_token_stall      (o_stall),
        .i_operation        (i_operation),
        .i_operand_value    (i_operand_value),
        .i_last_token       (i_last_token),
        .i_result_valid     (o_valid),
        .i_result_stall     (i_stall),
        .i_expression_value (o_expression_value),
        .i_status           (o_status),
        .i_end_check        (end_check),
        .o_error_count      (error_count),
        .o_pending          (pending_results),
        .o_token_count      (token_count),
        .o_result_count     (result_count),
        .o_flagged_count    (flagged_count)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Result side back-pressure
    always @(posedge i_clk) begin
        i_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #4_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Mostly random words, plus small values so zero divisors turn up, plus the word extremes
    function automatic t_word random_operand();
        case ($urandom_range(9))
            0, 1: begin
                return t_word'(int'($urandom_range(16)) - 8);
            end
            2: begin
                case ($urandom_range(4))
                    0:       return WORD_MIN;
                    1:       return WORD_MAX;
                    2:       return -32'sd1;
                    3:       return '0;
                    default: return 32'sd1;
                endcase
            end
            default: begin
                return t_word'($urandom);
            end
        endcase
    endfunction

    // One request on the token channel, with optional idle cycles ahead of it
    task automatic send_token(input logic [2:0] op, input t_word operand, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_operation     <= op;
        i_operand_value <= operand;
        i_last_token    <= last;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        // unknown codes that do not end an expression change nothing
        if (op <= OP_DIV || last) begin
            items_sent++;
        end
    endtask

    // Well-formed expression: operators only when two operands are stacked
    task automatic send_expression(input int max_operands);
        int         operands_left;
        int         depth;
        logic [2:0] op;
        operands_left = $urandom_range(max_operands, 1);
        depth = 0;
        while (operands_left > 0 || depth > 1) begin
            if (depth >= 2 && (operands_left == 0 || $urandom_range(2) == 0)) begin
                op = 3'($urandom_range(4, 1));
                depth--;
                send_token(op, t_word'($urandom), operands_left == 0 && depth == 1);
            end else begin
                operands_left--;
                depth++;
                send_token(OP_PUSH, random_operand(), operands_left == 0 && depth == 1);
            end
        end
    endtask

    // Short run of arbitrary tokens, any code, ending on a last token
    task automatic send_noise();
        int count;
        count = $urandom_range(6, 1);
        for (int k = 0; k < count; k++) begin
            send_token(3'($urandom_range(7)), random_operand(), k == count - 1);
        end
    endtask

    // More pushes than the stack holds, then an operator as the last token
    task automatic send_overflow();
        int count;
        count = $urandom_range(STACK_DEPTH + 4, STACK_DEPTH + 1);
        for (int k = 0; k < count; k++) begin
            send_token(OP_PUSH, random_operand(), 1'b0);
        end
        send_token(3'($urandom_range(4, 1)), t_word'($urandom), 1'b1);
    endtask

    initial begin
        int pick;
        int goal;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: single operand
        send_token(OP_PUSH, 32'sd7, 1'b1);
        // subtract takes the first popped value as its left operand
        send_token(OP_PUSH, 32'sd3, 1'b0);
        send_token(OP_PUSH, 32'sd10, 1'b0);
        send_token(OP_SUB, '0, 1'b1);
        // wrapping multiply and add
        send_token(OP_PUSH, WORD_MAX, 1'b0);
        send_token(OP_PUSH, WORD_MAX, 1'b0);
        send_token(OP_MUL, '0, 1'b0);
        send_token(OP_PUSH, WORD_MIN, 1'b0);
        send_token(OP_ADD, '0, 1'b1);
        // most negative over minus one
        send_token(OP_PUSH, -32'sd1, 1'b0);
        send_token(OP_PUSH, WORD_MIN, 1'b0);
        send_token(OP_DIV, '0, 1'b1);
        // divide by zero, then an underflow that must not replace it
        send_token(OP_PUSH, '0, 1'b0);
        send_token(OP_PUSH, 32'sd5, 1'b0);
        send_token(OP_DIV, '0, 1'b0);
        send_token(OP_ADD, '0, 1'b1);
        // last token on an empty stack
        send_token(OP_ADD, '0, 1'b1);
        // unknown codes leave the stack alone
        send_token(OP_PUSH, 32'sd9, 1'b0);
        send_token(3'd5, '1, 1'b0);
        send_token(3'd6, '0, 1'b0);
        send_token(3'd7, WORD_MIN, 1'b1);
        // operands left below the top
        send_token(OP_PUSH, 32'sd1, 1'b0);
        send_token(OP_PUSH, 32'sd2, 1'b1);

        // Random expressions, noise, overflow runs and lone operators under each idling pattern
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            goal = items_sent + PHASE_ITEMS;
            while (items_sent < goal) begin
                pick = $urandom_range(99);
                if (pick < 75) begin
                    send_expression(($urandom_range(9) == 0) ? STACK_DEPTH : 6);
                end else if (pick < 87) begin
                    send_noise();
                end else if (pick < 93) begin
                    send_overflow();
                end else begin
                    send_token(3'($urandom_range(4, 1)), t_word'($urandom), 1'b1);
                end
            end
        end
        i_valid <= 1'b0;

        // Let the checker count the final request, drain, then watch for strays
        @(posedge i_clk);
        while (pending_results != 0) begin
            @(posedge i_clk);
        end
        repeat (48) @(posedge i_clk);
        end_check <= 1'b1;
        repeat (2) @(posedge i_clk);

        $display("Run covered %0d tokens in four handshake phases, %0d expression results,",
                 token_count, result_count);
        $display("%0d of them carrying an underflow, overflow or divide-by-zero status.",
                 flagged_count);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/pxe_pkg.sv
rtl/pxe_stack_mem.sv
rtl/pxe_div.sv
rtl/prefix_expression_evaluator.sv
tb/prefix_expression_evaluator_checker.sv
tb/tb_prefix_expression_evaluator.sv
